// ----- src/salsa20_stream_xor_defines.svh -----
// Assertion macros shared by the salsa20_stream_xor RTL.
`ifndef SALSA20_STREAM_XOR_DEFINES_SVH
`define SALSA20_STREAM_XOR_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define S20SX_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("s20sx: assertion failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define S20SX_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("s20sx: assertion failed");

`endif

// ----- src/s20sx_pkg.sv -----
// Types, constants and round functions for the Salsa20 stream XOR block.
package s20sx_pkg;

    localparam int DoubleRoundsDef = 10;

    typedef logic [31:0] t_word;
    typedef t_word [15:0] t_block;
    typedef t_word [3:0] t_quad;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_FFWD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic load;
        logic round;
        logic row;
        logic ffwd;
        logic emit;
        logic use_held;
        logic cfg_write;
    } t_cmd;

    typedef struct packed {
        logic off_zero;
        logic out_free;
    } t_stat;

    localparam logic [2:0] CFG_KEY0  = 3'd0;
    localparam logic [2:0] CFG_KEY1  = 3'd1;
    localparam logic [2:0] CFG_KEY2  = 3'd2;
    localparam logic [2:0] CFG_KEY3  = 3'd3;
    localparam logic [2:0] CFG_LONG  = 3'd4;
    localparam logic [2:0] CFG_NONCE = 3'd5;
    localparam logic [2:0] CFG_START = 3'd6;

    localparam t_word CONST_W0      = 32'h6170_7865;
    localparam t_word CONST_W5_32   = 32'h3320_646e;
    localparam t_word CONST_W5_16   = 32'h3120_646e;
    localparam t_word CONST_W10_32  = 32'h7962_2d32;
    localparam t_word CONST_W10_16  = 32'h7962_2d36;
    localparam t_word CONST_W15     = 32'h6b20_6574;

    function automatic t_word rotl(input t_word v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Returns {a, b, c, d} as elements [0] to [3].
    function automatic t_quad quarter(input t_word a, input t_word b,
                                      input t_word c, input t_word d);
        t_quad q;
        q[1] = b ^ rotl(a + d, 7);
        q[2] = c ^ rotl(q[1] + a, 9);
        q[3] = d ^ rotl(q[2] + q[1], 13);
        q[0] = a ^ rotl(q[3] + q[2], 18);
        return q;
    endfunction

    // Four column quarter-rounds; each starts on a diagonal word.
    function automatic t_block col_round(input t_block x);
        t_block y;
        t_quad  q;
        y = x;
        for (int k = 0; k < 4; k++) begin
            q = quarter(x[4'(5 * k)], x[4'(5 * k + 4)], x[4'(5 * k + 8)], x[4'(5 * k + 12)]);
            y[4'(5 * k)]      = q[0];
            y[4'(5 * k + 4)]  = q[1];
            y[4'(5 * k + 8)]  = q[2];
            y[4'(5 * k + 12)] = q[3];
        end
        return y;
    endfunction

    // Row round equals a column round on the transposed 4x4 state.
    function automatic t_block transpose(input t_block x);
        t_block y;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                y[4'(4 * c + r)] = x[4'(4 * r + c)];
            end
        end
        return y;
    endfunction

endpackage

// ----- src/salsa20_stream_xor.sv -----
// Salsa20 stream XOR top level: 8-byte chunks in, XORed chunks out.
// A chunk that opens a 64-byte keystream block passes through these steps
// (load, one column or row round per cycle through four quarter-round units,
// feed-forward add, output); the default is 10 double rounds.
// Every other chunk of the block is XORed and registered as it is accepted,
// whenever the output register is free. Configuration writes are taken while
// no block is being computed; any write to a valid index reloads the block
// counter from start_count and restarts at block offset zero. No clearing pass
// after reset.

module salsa20_stream_xor #(
    parameter int DOUBLE_ROUNDS = s20sx_pkg::DoubleRoundsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_in_data,
    input  logic [3:0]  i_byte_count,
    input  logic        i_end_of_call,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_out_data,
    output logic [3:0]  o_out_count,
    output logic        o_out_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    s20sx_pkg::t_cmd  w_cmd;
    s20sx_pkg::t_stat w_stat;

    s20sx_ctrl #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    s20sx_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_data     (i_in_data),
        .i_byte_count  (i_byte_count),
        .i_end_of_call (i_end_of_call),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data),
        .o_out_count   (o_out_count),
        .o_out_last    (o_out_last)
    );

endmodule

// ----- src/s20sx_ctrl.sv -----
// Controller state machine for the Salsa20 stream XOR block.
`include "salsa20_stream_xor_defines.svh"

module s20sx_ctrl #(
    parameter int DOUBLE_ROUNDS = s20sx_pkg::DoubleRoundsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  s20sx_pkg::t_stat   i_stat,
    output s20sx_pkg::t_cmd    o_cmd
);

    localparam int Rounds = 2 * DOUBLE_ROUNDS;
    localparam int CntW   = $clog2(Rounds);
    localparam logic [CntW-1:0] LastRnd = CntW'(Rounds - 1);

    s20sx_pkg::t_state r_state, n_state;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic              w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= s20sx_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        unique case (r_state)
            s20sx_pkg::S_IDLE: begin
                if (w_accept && i_stat.off_zero) begin
                    n_state = s20sx_pkg::S_ROUND;
                end
            end
            s20sx_pkg::S_ROUND: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LastRnd) begin
                    n_state = s20sx_pkg::S_FFWD;
                    n_cnt   = '0;
                end
            end
            s20sx_pkg::S_FFWD: begin
                n_state = s20sx_pkg::S_EMIT;
            end
            s20sx_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = s20sx_pkg::S_IDLE;
                end
            end
            default: n_state = s20sx_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        o_cmd       = '0;
        w_accept    = 1'b0;
        unique case (r_state)
            s20sx_pkg::S_IDLE: begin
                o_in_ready      = i_rst_n && (i_stat.off_zero || i_stat.out_free);
                o_cfg_ready     = i_rst_n;
                o_cmd.cfg_write = i_cfg_valid && o_cfg_ready;
                w_accept        = i_in_valid && o_in_ready;
                o_cmd.capture   = w_accept;
                o_cmd.load      = w_accept && i_stat.off_zero;
                o_cmd.emit      = w_accept && !i_stat.off_zero;
            end
            s20sx_pkg::S_ROUND: begin
                o_cmd.round = 1'b1;
                o_cmd.row   = r_cnt[0];
            end
            s20sx_pkg::S_FFWD: begin
                o_cmd.ffwd = 1'b1;
            end
            s20sx_pkg::S_EMIT: begin
                o_cmd.emit     = i_stat.out_free;
                o_cmd.use_held = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    `S20SX_ASSERT_NXT(a_load_starts_rounds, o_cmd.load, r_state == s20sx_pkg::S_ROUND)
    `S20SX_ASSERT_NXT(a_last_round_ffwd,
        (r_state == s20sx_pkg::S_ROUND) && (r_cnt == LastRnd), r_state == s20sx_pkg::S_FFWD)

endmodule

// ----- src/s20sx_core.sv -----
// Datapath: configuration, keystream state, quarter-round array and output register.
`include "salsa20_stream_xor_defines.svh"

module s20sx_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  s20sx_pkg::t_cmd   i_cmd,
    output s20sx_pkg::t_stat  o_stat,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  logic [63:0]       i_in_data,
    input  logic [3:0]        i_byte_count,
    input  logic              i_end_of_call,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [63:0]       o_out_data,
    output logic [3:0]        o_out_count,
    output logic              o_out_last
);

    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_nonce, r_start, r_counter;
    logic        r_long_key;
    logic [2:0]  r_off;
    s20sx_pkg::t_block r_work, n_work, w_init;
    logic [63:0] r_hold_data;
    logic [3:0]  r_hold_count;
    logic        r_hold_last;
    logic        r_out_valid;
    logic [63:0] r_out_data, n_out_data;
    logic [3:0]  r_out_count, n_out_count;
    logic        r_out_last;

    logic [63:0] w_hi0, w_hi1, w_ks, w_src_data;
    logic [3:0]  w_src_count;
    logic        w_src_last;
    logic        w_cfg_hit;

    assign w_cfg_hit = i_cmd.cfg_write && (i_cfg_index <= s20sx_pkg::CFG_START);

    assign w_hi0 = r_long_key ? r_key2 : r_key0;
    assign w_hi1 = r_long_key ? r_key3 : r_key1;

    always_comb begin
        w_init[0]  = s20sx_pkg::CONST_W0;
        w_init[1]  = r_key0[31:0];
        w_init[2]  = r_key0[63:32];
        w_init[3]  = r_key1[31:0];
        w_init[4]  = r_key1[63:32];
        w_init[5]  = r_long_key ? s20sx_pkg::CONST_W5_32 : s20sx_pkg::CONST_W5_16;
        w_init[6]  = r_nonce[31:0];
        w_init[7]  = r_nonce[63:32];
        w_init[8]  = r_counter[31:0];
        w_init[9]  = r_counter[63:32];
        w_init[10] = r_long_key ? s20sx_pkg::CONST_W10_32 : s20sx_pkg::CONST_W10_16;
        w_init[11] = w_hi0[31:0];
        w_init[12] = w_hi0[63:32];
        w_init[13] = w_hi1[31:0];
        w_init[14] = w_hi1[63:32];
        w_init[15] = s20sx_pkg::CONST_W15;
    end

    always_comb begin
        n_work = r_work;
        if (i_cmd.load) begin
            n_work = w_init;
        end else if (i_cmd.round) begin
            if (i_cmd.row) begin
                n_work = s20sx_pkg::transpose(
                    s20sx_pkg::col_round(s20sx_pkg::transpose(r_work)));
            end else begin
                n_work = s20sx_pkg::col_round(r_work);
            end
        end else if (i_cmd.ffwd) begin
            for (int i = 0; i < 16; i++) begin
                n_work[4'(i)] = r_work[4'(i)] + w_init[4'(i)];
            end
        end
    end

    assign w_src_data  = i_cmd.use_held ? r_hold_data  : i_in_data;
    assign w_src_count = i_cmd.use_held ? r_hold_count : i_byte_count;
    assign w_src_last  = i_cmd.use_held ? r_hold_last  : i_end_of_call;
    assign w_ks        = {r_work[{r_off, 1'b1}], r_work[{r_off, 1'b0}]};

    always_comb begin
        priority if (w_src_count == 4'd0) begin
            n_out_count = 4'd1;
        end else if (w_src_count > 4'd8) begin
            n_out_count = 4'd8;
        end else begin
            n_out_count = w_src_count;
        end
        for (int b = 0; b < 8; b++) begin
            n_out_data[8*b +: 8] = (4'(b) < n_out_count) ?
                (w_src_data[8*b +: 8] ^ w_ks[8*b +: 8]) : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0      <= '0;
            r_key1      <= '0;
            r_key2      <= '0;
            r_key3      <= '0;
            r_long_key  <= 1'b1;
            r_nonce     <= '0;
            r_start     <= '0;
            r_counter   <= '0;
            r_off       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_write) begin
                unique case (i_cfg_index)
                    s20sx_pkg::CFG_KEY0:  r_key0     <= i_cfg_data;
                    s20sx_pkg::CFG_KEY1:  r_key1     <= i_cfg_data;
                    s20sx_pkg::CFG_KEY2:  r_key2     <= i_cfg_data;
                    s20sx_pkg::CFG_KEY3:  r_key3     <= i_cfg_data;
                    s20sx_pkg::CFG_LONG:  r_long_key <= i_cfg_data[0];
                    s20sx_pkg::CFG_NONCE: r_nonce    <= i_cfg_data;
                    s20sx_pkg::CFG_START: r_start    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_cfg_hit) begin
                r_counter <= (i_cfg_index == s20sx_pkg::CFG_START) ? i_cfg_data : r_start;
                r_off     <= '0;
            end else begin
                if (i_cmd.ffwd) begin
                    r_counter <= r_counter + 64'd1;
                end
                if (i_cmd.emit) begin
                    r_off <= w_src_last ? 3'd0 : r_off + 3'd1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        if (i_cmd.capture) begin
            r_hold_data  <= i_in_data;
            r_hold_count <= i_byte_count;
            r_hold_last  <= i_end_of_call;
        end
        if (i_cmd.emit) begin
            r_out_data  <= n_out_data;
            r_out_count <= n_out_count;
            r_out_last  <= w_src_last;
        end
    end

    assign o_stat.off_zero = (r_off == 3'd0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_count = r_out_count;
    assign o_out_last  = r_out_last;

    `S20SX_ASSERT_IMP(a_emit_slot_free, i_cmd.emit, o_stat.out_free)
    `S20SX_ASSERT_IMP(a_load_at_block_start, i_cmd.load, r_off == 3'd0)
    `S20SX_ASSERT_NXT(a_ffwd_bumps_counter, i_cmd.ffwd && !w_cfg_hit,
        r_counter == $past(r_counter) + 64'd1)

endmodule
